>>> rtl/sfa_pkg.sv
package sfa_pkg;

	localparam int unsigned LIMB_W = 64;
	localparam int unsigned ELEM_W = 256;
	localparam int unsigned OP_W   = 3;

	localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
	localparam logic [OP_W-1:0] OP_SQR  = 3'd3;
	localparam logic [OP_W-1:0] OP_NEG  = 3'd4;
	localparam logic [OP_W-1:0] OP_INV  = 3'd5;
	localparam logic [OP_W-1:0] OP_SQRT = 3'd6;

	localparam logic [ELEM_W-1:0] PRIME = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
		64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2F};

	// p - 2
	localparam logic [ELEM_W-1:0] INV_EXP = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
		64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2D};

	// (p + 1) / 4
	localparam logic [ELEM_W-1:0] SQRT_EXP = {64'h3FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
		64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFBFFFFF0C};

	// 2^256 mod p = 2^32 + FOLD_LO
	localparam logic [31:0] FOLD_LO = 32'd977;

endpackage

>>> rtl/sfa_fmul.sv
module sfa_fmul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sfa_pkg::ELEM_W-1:0]  x,
	input  logic [sfa_pkg::ELEM_W-1:0]  y,
	output logic                        done,
	output logic [sfa_pkg::ELEM_W-1:0]  res
);

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_PROD  = 3'd1;
	localparam logic [2:0] M_FOLDA = 3'd2;
	localparam logic [2:0] M_FOLDB = 3'd3;
	localparam logic [2:0] M_FINAL = 3'd4;

	logic [2:0]   state_q;
	logic [5:0]   cnt_q;
	logic [255:0] x_q, y_q, h_q, res_q;
	logic [511:0] acc_q;
	logic         done_q;

	logic [31:0]  mx, my;
	logic [63:0]  pp;
	logic [3:0]   sh;
	logic [511:0] pp_ext;
	logic [255:0] lo;

	always_comb begin
		if (state_q == M_FOLDB) begin
			mx = h_q[{cnt_q[2:0], 5'b0} +: 32];
			my = sfa_pkg::FOLD_LO;
			sh = {1'b0, cnt_q[2:0]};
		end else begin
			mx = x_q[{cnt_q[5:3], 5'b0} +: 32];
			my = y_q[{cnt_q[2:0], 5'b0} +: 32];
			sh = {1'b0, cnt_q[5:3]} + {1'b0, cnt_q[2:0]};
		end
		pp = {32'b0, mx} * {32'b0, my};
		pp_ext = {448'b0, pp} << {sh, 5'b0};
		lo = acc_q[255:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_PROD;
						cnt_q   <= '0;
					end
				end
				M_PROD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= M_FOLDA;
				end
				M_FOLDA: begin
					cnt_q <= '0;
					if (acc_q[511:256] == '0) state_q <= M_FINAL;
					else state_q <= M_FOLDB;
				end
				M_FOLDB: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[2:0] == 3'd7) state_q <= M_FOLDA;
				end
				M_FINAL: begin
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start) begin
					x_q   <= x;
					y_q   <= y;
					acc_q <= '0;
				end
			end
			M_PROD, M_FOLDB: acc_q <= acc_q + pp_ext;
			M_FOLDA: begin
				h_q   <= acc_q[511:256];
				acc_q <= {256'b0, lo} + ({256'b0, acc_q[511:256]} << 32);
			end
			M_FINAL: res_q <= (lo >= sfa_pkg::PRIME) ? lo - sfa_pkg::PRIME : lo;
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> rtl/secp256k1_field_alu.sv
// add, sub, negate: an add or subtract state, then the done state, which sets out_valid;
// negate of zero and unused code go straight to the done state
// multiply and square run one product (up to three folds); inverse and square root
// run about 505 products; one item at a time; each product is 64 steps of a 32x32
// multiplier plus folding; the next item is taken once the previous one is done
// reset: arst_n asynchronous active low clears the sequencer and the output valid
module secp256k1_field_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sfa_pkg::OP_W-1:0]      operation,
	input  logic [sfa_pkg::LIMB_W-1:0]    operand_a_limb0,
	input  logic [sfa_pkg::LIMB_W-1:0]    operand_a_limb1,
	input  logic [sfa_pkg::LIMB_W-1:0]    operand_a_limb2,
	input  logic [sfa_pkg::LIMB_W-1:0]    operand_a_limb3,
	input  logic [sfa_pkg::LIMB_W-1:0]    operand_b_limb0,
	input  logic [sfa_pkg::LIMB_W-1:0]    operand_b_limb1,
	input  logic [sfa_pkg::LIMB_W-1:0]    operand_b_limb2,
	input  logic [sfa_pkg::LIMB_W-1:0]    operand_b_limb3,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sfa_pkg::LIMB_W-1:0]    result_limb0,
	output logic [sfa_pkg::LIMB_W-1:0]    result_limb1,
	output logic [sfa_pkg::LIMB_W-1:0]    result_limb2,
	output logic [sfa_pkg::LIMB_W-1:0]    result_limb3,
	output logic                          root_valid
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD  = 3'd1;
	localparam logic [2:0] S_SUB  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_EXSQ = 3'd4;
	localparam logic [2:0] S_EXML = 3'd5;
	localparam logic [2:0] S_CHK  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]   state_q;
	logic [2:0]   op_q;
	logic [255:0] a_q, r_q, mx_q, my_q;
	logic [256:0] t_q;
	logic [7:0]   bit_q;
	logic         rv_q, go_q, out_valid_q;
	logic [255:0] res_out_q;
	logic         root_out_q;

	logic [255:0] a_in, b_in, exp_w, mres;
	logic         mdone, accept, exp_bit;

	assign a_in = {operand_a_limb3, operand_a_limb2, operand_a_limb1, operand_a_limb0};
	assign b_in = {operand_b_limb3, operand_b_limb2, operand_b_limb1, operand_b_limb0};
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign exp_w = (op_q == sfa_pkg::OP_INV) ? sfa_pkg::INV_EXP : sfa_pkg::SQRT_EXP;
	assign exp_bit = exp_w[bit_q];

	sfa_fmul u_fmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.x      (mx_q),
		.y      (my_q),
		.done   (mdone),
		.res    (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							sfa_pkg::OP_ADD: state_q <= S_ADD;
							sfa_pkg::OP_SUB: state_q <= S_SUB;
							sfa_pkg::OP_NEG: state_q <= (a_in == '0) ? S_DONE : S_SUB;
							sfa_pkg::OP_MUL, sfa_pkg::OP_SQR: begin
								go_q    <= 1'b1;
								state_q <= S_MUL;
							end
							sfa_pkg::OP_INV, sfa_pkg::OP_SQRT: begin
								go_q    <= 1'b1;
								state_q <= S_EXSQ;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ADD, S_SUB: state_q <= S_DONE;
				S_MUL, S_CHK: if (mdone) state_q <= S_DONE;
				S_EXSQ, S_EXML: begin
					if (mdone) begin
						go_q <= 1'b1;
						if (state_q == S_EXSQ && exp_bit) state_q <= S_EXML;
						else if (bit_q != 8'd0) state_q <= S_EXSQ;
						else if (op_q == sfa_pkg::OP_SQRT) state_q <= S_CHK;
						else begin
							go_q    <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= operation;
					a_q   <= a_in;
					rv_q  <= 1'b0;
					r_q   <= '0;
					bit_q <= 8'd255;
					mx_q  <= a_in;
					my_q  <= (operation == sfa_pkg::OP_SQR) ? a_in : b_in;
					if (operation == sfa_pkg::OP_INV || operation == sfa_pkg::OP_SQRT) begin
						mx_q <= 256'd1;
						my_q <= 256'd1;
					end
					if (operation == sfa_pkg::OP_ADD) t_q <= {1'b0, a_in} + {1'b0, b_in};
					else if (operation == sfa_pkg::OP_NEG)
						t_q <= {1'b0, sfa_pkg::PRIME} - {1'b0, a_in};
					else t_q <= {1'b0, a_in} - {1'b0, b_in};
				end
			end
			S_ADD: r_q <= (t_q >= {1'b0, sfa_pkg::PRIME}) ? t_q[255:0] - sfa_pkg::PRIME
				: t_q[255:0];
			S_SUB: r_q <= t_q[256] ? t_q[255:0] + sfa_pkg::PRIME : t_q[255:0];
			S_MUL: if (mdone) r_q <= mres;
			S_EXSQ, S_EXML: begin
				if (mdone) begin
					r_q  <= mres;
					mx_q <= mres;
					if (state_q == S_EXSQ && exp_bit) my_q <= a_q;
					else begin
						my_q  <= mres;
						bit_q <= bit_q - 8'd1;
					end
				end
			end
			S_CHK: if (mdone) rv_q <= (mres == a_q);
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					res_out_q  <= r_q;
					root_out_q <= rv_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_limb0 = res_out_q[63:0];
	assign result_limb1 = res_out_q[127:64];
	assign result_limb2 = res_out_q[191:128];
	assign result_limb3 = res_out_q[255:192];
	assign root_valid   = root_out_q;

endmodule

>>> rtl/sfa_checker.sv
module sfa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [sfa_pkg::LIMB_W-1:0]  result_limb0,
	input logic                        root_valid
);

	// one item in flight: a taken beat blocks the input next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output beat dropped under stall");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(result_limb0) && $stable(root_valid)))
		else $error("output payload changed under stall");

endmodule

bind secp256k1_field_alu sfa_checker u_sfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_limb0 (result_limb0),
	.root_valid   (root_valid)
);

>>> dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [sfa_pkg::OP_W-1:0] OP_NONE = 3'd7;
	localparam int unsigned IDLE_LIMIT = 300000;
	localparam logic [sfa_pkg::ELEM_W-1:0] ALL_ONES = {sfa_pkg::ELEM_W{1'b1}};

	typedef struct packed {
		logic [sfa_pkg::ELEM_W-1:0] value;
		logic                       root_ok;
	} field_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [sfa_pkg::OP_W-1:0] operation = '0;
	logic [sfa_pkg::ELEM_W-1:0] operand_a = '0;
	logic [sfa_pkg::ELEM_W-1:0] operand_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [sfa_pkg::LIMB_W-1:0] result_limb0, result_limb1, result_limb2, result_limb3;
	logic root_valid;

	field_result_t pending_results[$];
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_hold = 0;
	bit quiet = 1'b0;

	always #5 clk = ~clk;

	secp256k1_field_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.operand_a_limb0(operand_a[63:0]), .operand_a_limb1(operand_a[127:64]),
		.operand_a_limb2(operand_a[191:128]), .operand_a_limb3(operand_a[255:192]),
		.operand_b_limb0(operand_b[63:0]), .operand_b_limb1(operand_b[127:64]),
		.operand_b_limb2(operand_b[191:128]), .operand_b_limb3(operand_b[255:192]),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_limb0(result_limb0), .result_limb1(result_limb1),
		.result_limb2(result_limb2), .result_limb3(result_limb3),
		.root_valid(root_valid)
	);

	function automatic logic [sfa_pkg::ELEM_W-1:0] mod_mul(logic [sfa_pkg::ELEM_W-1:0] x,
		logic [sfa_pkg::ELEM_W-1:0] y);
		logic [2*sfa_pkg::ELEM_W-1:0] prod, rem;
		prod = {{sfa_pkg::ELEM_W{1'b0}}, x} * {{sfa_pkg::ELEM_W{1'b0}}, y};
		rem = prod % {{sfa_pkg::ELEM_W{1'b0}}, sfa_pkg::PRIME};
		return rem[sfa_pkg::ELEM_W-1:0];
	endfunction

	function automatic logic [sfa_pkg::ELEM_W-1:0] mod_pow(logic [sfa_pkg::ELEM_W-1:0] x,
		logic [sfa_pkg::ELEM_W-1:0] e);
		logic [sfa_pkg::ELEM_W-1:0] acc;
		acc = 1;
		for (int i = sfa_pkg::ELEM_W - 1; i >= 0; i--) begin
			acc = mod_mul(acc, acc);
			if (e[i])
				acc = mod_mul(acc, x);
		end
		return acc;
	endfunction

	function automatic logic [sfa_pkg::ELEM_W-1:0] raw_sub(logic [sfa_pkg::ELEM_W-1:0] x,
		logic [sfa_pkg::ELEM_W-1:0] y);
		logic [sfa_pkg::ELEM_W-1:0] d;
		d = x - y;
		if (x < y)
			d = d + sfa_pkg::PRIME;
		return d;
	endfunction

	function automatic field_result_t field_op(logic [sfa_pkg::OP_W-1:0] op,
		logic [sfa_pkg::ELEM_W-1:0] a, logic [sfa_pkg::ELEM_W-1:0] b);
		field_result_t r;
		logic [sfa_pkg::ELEM_W:0] sum;
		r = '0;
		case (op)
			sfa_pkg::OP_ADD: begin
				sum = {1'b0, a} + {1'b0, b};
				r.value = sum[sfa_pkg::ELEM_W-1:0];
				if (sum[sfa_pkg::ELEM_W] || r.value >= sfa_pkg::PRIME)
					r.value = r.value - sfa_pkg::PRIME;
			end
			sfa_pkg::OP_SUB: r.value = raw_sub(a, b);
			sfa_pkg::OP_MUL: r.value = mod_mul(a, b);
			sfa_pkg::OP_SQR: r.value = mod_mul(a, a);
			sfa_pkg::OP_NEG: if (a != 0) r.value = raw_sub(sfa_pkg::PRIME, a);
			sfa_pkg::OP_INV: r.value = mod_pow(a, sfa_pkg::INV_EXP);
			sfa_pkg::OP_SQRT: begin
				r.value = mod_pow(a, sfa_pkg::SQRT_EXP);
				r.root_ok = (mod_mul(r.value, r.value) == a);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [sfa_pkg::ELEM_W-1:0] rand_wide();
		logic [sfa_pkg::ELEM_W-1:0] v;
		for (int i = 0; i < 8; i++)
			v[32*i +: 32] = $urandom;
		return v;
	endfunction

	// mostly in-field values, with small, near-p and above-p corners
	function automatic logic [sfa_pkg::ELEM_W-1:0] rand_elem();
		logic [sfa_pkg::ELEM_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = {224'b0, $urandom_range(0, 3)};
			1: v = sfa_pkg::PRIME - $urandom_range(1, 3);
			2: v = sfa_pkg::PRIME + $urandom_range(0, 3);
			3: v = ALL_ONES - $urandom_range(0, 3);
			default: begin
				v = rand_wide();
				if (v >= sfa_pkg::PRIME)
					v = v - sfa_pkg::PRIME;
			end
		endcase
		return v;
	endfunction

	task automatic send_beat(logic [sfa_pkg::OP_W-1:0] op, logic [sfa_pkg::ELEM_W-1:0] a,
		logic [sfa_pkg::ELEM_W-1:0] b);
		int unsigned gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		pending_results.push_back(field_op(op, a, b));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_add_sub_neg();
		send_beat(sfa_pkg::OP_ADD, 0, 0);
		send_beat(sfa_pkg::OP_ADD, sfa_pkg::PRIME - 1, 1);
		send_beat(sfa_pkg::OP_ADD, ALL_ONES, ALL_ONES);
		send_beat(sfa_pkg::OP_ADD, sfa_pkg::PRIME - 1, sfa_pkg::PRIME - 1);
		send_beat(sfa_pkg::OP_SUB, 0, 1);
		send_beat(sfa_pkg::OP_SUB, 5, 5);
		send_beat(sfa_pkg::OP_SUB, 0, ALL_ONES);
		send_beat(sfa_pkg::OP_NEG, 0, ALL_ONES);
		send_beat(sfa_pkg::OP_NEG, 1, 0);
		send_beat(sfa_pkg::OP_NEG, ALL_ONES, 0);
		send_beat(OP_NONE, ALL_ONES, ALL_ONES);
	endtask

	task automatic test_mul_sqr();
		send_beat(sfa_pkg::OP_MUL, sfa_pkg::PRIME - 1, sfa_pkg::PRIME - 1);
		send_beat(sfa_pkg::OP_MUL, ALL_ONES, ALL_ONES);
		send_beat(sfa_pkg::OP_MUL, 0, ALL_ONES);
		send_beat(sfa_pkg::OP_SQR, ALL_ONES, 0);
		send_beat(sfa_pkg::OP_SQR, sfa_pkg::PRIME, 0);
		send_beat(sfa_pkg::OP_MUL, rand_wide(), rand_wide());
	endtask

	task automatic test_inv_sqrt();
		logic [sfa_pkg::ELEM_W-1:0] x;
		x = rand_elem();
		send_beat(sfa_pkg::OP_INV, 0, 0);
		send_beat(sfa_pkg::OP_INV, sfa_pkg::PRIME - 1, 0);
		send_beat(sfa_pkg::OP_SQRT, mod_mul(x, x), 0);
		send_beat(sfa_pkg::OP_SQRT, sfa_pkg::PRIME - 1, 0);
		send_beat(sfa_pkg::OP_SQRT, sfa_pkg::PRIME + 4, 0);
	endtask

	task automatic test_random(int unsigned count);
		logic [sfa_pkg::OP_W-1:0] op;
		logic [sfa_pkg::ELEM_W-1:0] a;
		int unsigned pick;
		int unsigned sel;
		for (int unsigned n = 0; n < count; n++) begin
			if (n == count - 100)
				quiet = 1'b1;
			pick = $urandom_range(0, 199);
			sel = $urandom_range(0, 4);
			// inverse and root are very slow, keep them rare
			if (pick < 2)
				op = sfa_pkg::OP_INV;
			else if (pick < 4)
				op = sfa_pkg::OP_SQRT;
			else if (pick < 6)
				op = OP_NONE;
			else
				op = sel[sfa_pkg::OP_W-1:0];
			a = rand_elem();
			if (op == sfa_pkg::OP_SQRT && $urandom_range(0, 1) == 0)
				a = mod_mul(a, a);
			send_beat(op, a, rand_elem());
			if (n == count / 2)
				wait_drained();
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || quiet)
			out_stall <= 1'b0;
		else if (stall_hold > 0) begin
			out_stall <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_hold <= $urandom_range(0, 14);
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		field_result_t exp_r;
		logic [sfa_pkg::LIMB_W-1:0] got_limb[4];
		if (out_valid && !out_stall) begin
			got_limb = '{result_limb0, result_limb1, result_limb2, result_limb3};
			if (pending_results.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				for (int i = 0; i < 4; i++)
					if (got_limb[i] !== exp_r.value[64*i +: 64]) begin
						$error("result_limb%0d expected %h got %h", i,
							exp_r.value[64*i +: 64], got_limb[i]);
						errors++;
					end
				if (root_valid !== exp_r.root_ok) begin
					$error("root_valid expected %0b got %0b", exp_r.root_ok, root_valid);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("secp256k1_field_alu: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_add_sub_neg();
		test_mul_sqr();
		test_inv_sqrt();
		wait_drained();
		test_random(525);
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("secp256k1_field_alu: match");
		else
			$display("secp256k1_field_alu: mismatch");
		$finish;
	end
endmodule
